FILE: rtl/spq_pkg.sv
// Shared codes and types for the sorted priority queue.
package spq_pkg;

  // Operation code carried by the kind field
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Outcome reported with every result item
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  // Completion flags from the sequencer to the output stage
  typedef struct packed {
    logic        valid;
    logic        empty;
    spq_status_t status;
  } spq_done_t;

endpackage

FILE: rtl/spq_req_if.sv
// Request channel: one push or pop item per handshake.
interface spq_req_if #(
  parameter int ELEM_WIDTH = 32,
  parameter int PRIO_WIDTH = 8
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [ELEM_WIDTH-1:0] elem;
  logic [PRIO_WIDTH-1:0] priority_req;

  modport source (output valid, kind, elem, priority_req, input ready);
  modport sink   (input valid, kind, elem, priority_req, output ready);
endinterface

FILE: rtl/spq_rsp_if.sv
// Response channel: queue head, fill level and status after each item.
interface spq_rsp_if #(
  parameter int CAPACITY   = 16,
  parameter int ELEM_WIDTH = 32,
  parameter int PRIO_WIDTH = 8
);
  localparam int CntWidth = $clog2(CAPACITY + 1);

  logic                  valid;
  logic                  ready;
  logic [ELEM_WIDTH-1:0] top_elem;
  logic [PRIO_WIDTH-1:0] top_priority;
  logic                  is_empty;
  logic [CntWidth-1:0]   count;
  logic [1:0]            status;

  modport source (output valid, top_elem, top_priority, is_empty, count, status,
                  input ready);
  modport sink   (input valid, top_elem, top_priority, is_empty, count, status,
                  output ready);
endinterface

FILE: rtl/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered and valid in the cycle after the address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/spq_seq.sv
// Sequencer: insertion walk, head pointer, shared address adder and comparator.
module spq_seq import spq_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int ELEM_WIDTH = 32,
  parameter int PRIO_WIDTH = 8,
  localparam int AddrWidth = $clog2(CAPACITY),
  localparam int CntWidth  = $clog2(CAPACITY + 1),
  localparam int DataWidth = ELEM_WIDTH + PRIO_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  kind,
  input  logic [ELEM_WIDTH-1:0] elem,
  input  logic [PRIO_WIDTH-1:0] prio,
  input  logic                  res_free,
  output logic                  idle,
  output spq_done_t             done,
  output logic [ELEM_WIDTH-1:0] head_elem,
  output logic [PRIO_WIDTH-1:0] head_prio,
  output logic [CntWidth-1:0]   count,
  output logic                  wr_en,
  output logic [AddrWidth-1:0]  wr_addr,
  output logic [DataWidth-1:0]  wr_data,
  output logic                  rd_en,
  output logic [AddrWidth-1:0]  rd_addr,
  input  logic [DataWidth-1:0]  rd_data
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_PUSH_RD   = 6'b000010,
    S_PUSH_CMP  = 6'b000100,
    S_HEAD      = 6'b001000,
    S_HEAD_WAIT = 6'b010000,
    S_FINISH    = 6'b100000
  } state_t;

  state_t                state;
  logic [AddrWidth-1:0]  head;
  logic [AddrWidth-1:0]  slot;
  logic [ELEM_WIDTH-1:0] new_elem;
  logic [PRIO_WIDTH-1:0] new_prio;
  spq_status_t           status;

  logic [AddrWidth-1:0]  offset;
  logic [AddrWidth:0]    sum;
  logic [AddrWidth-1:0]  phys;
  logic [PRIO_WIDTH-1:0] rd_prio;
  logic                  keep_order;
  logic                  full;

  // Shared address unit: logical position to RAM address, ring wrap
  always_comb begin
    offset = '0;
    case (state)
      S_IDLE:     offset = AddrWidth'(1);
      S_PUSH_RD:  offset = (slot == '0) ? '0 : slot - 1'b1;
      S_PUSH_CMP: offset = slot;
      default:    offset = '0;
    endcase
    sum  = {1'b0, head} + {1'b0, offset};
    phys = (sum >= (AddrWidth+1)'(CAPACITY)) ?
           AddrWidth'(sum - (AddrWidth+1)'(CAPACITY)) : sum[AddrWidth-1:0];
  end

  // Shared comparator: stored entry stays ahead of the new one
  assign rd_prio    = rd_data[PRIO_WIDTH-1:0];
  assign keep_order = (rd_prio >= new_prio);
  assign full       = (count == CntWidth'(CAPACITY));

  // RAM access
  assign wr_en   = ((state == S_PUSH_RD) && (slot == '0)) || (state == S_PUSH_CMP);
  assign wr_addr = phys;
  assign wr_data = ((state == S_PUSH_CMP) && !keep_order) ? rd_data
                                                          : {new_elem, new_prio};
  assign rd_en   = ((state == S_PUSH_RD) && (slot != '0)) ||
                   ((state == S_HEAD) && (count != '0));
  assign rd_addr = phys;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      head  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (kind == KIND_PUSH) begin
              state <= full ? S_HEAD : S_PUSH_RD;
            end else begin
              if (count != '0) begin
                head  <= phys;
                count <= count - 1'b1;
              end
              state <= S_HEAD;
            end
          end
        end
        S_PUSH_RD: begin
          if (slot == '0) begin
            count <= count + 1'b1;
            state <= S_HEAD;
          end else begin
            state <= S_PUSH_CMP;
          end
        end
        S_PUSH_CMP: begin
          if (keep_order) begin
            count <= count + 1'b1;
            state <= S_HEAD;
          end else begin
            state <= S_PUSH_RD;
          end
        end
        S_HEAD: begin
          state <= (count == '0) ? S_FINISH : S_HEAD_WAIT;
        end
        S_HEAD_WAIT: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item payload, walk position and captured head
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          new_elem <= elem;
          new_prio <= prio;
          slot     <= count[AddrWidth-1:0];
          if ((kind == KIND_PUSH) && full) begin
            status <= ST_FULL;
          end else if ((kind == KIND_POP) && (count == '0)) begin
            status <= ST_EMPTY;
          end else begin
            status <= ST_OK;
          end
        end
      end
      S_PUSH_CMP: begin
        if (!keep_order) begin
          slot <= slot - 1'b1;
        end
      end
      S_HEAD: begin
        if (count == '0) begin
          head_elem <= '0;
          head_prio <= '0;
        end
      end
      S_HEAD_WAIT: begin
        head_elem <= rd_data[DataWidth-1:PRIO_WIDTH];
        head_prio <= rd_prio;
      end
      default: begin
      end
    endcase
  end

  assign idle         = (state == S_IDLE);
  assign done.valid   = (state == S_FINISH) && res_free;
  assign done.empty   = (count == '0);
  assign done.status  = status;

  // A successful pop takes exactly one entry
  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && start && (kind == KIND_POP) && (count != '0)
    |=> count == $past(count) - 1'b1)
    else $error("pop did not decrement the entry count");

  // A rejected item leaves the fill level alone
  a_reject_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && start &&
    (((kind == KIND_PUSH) && full) || ((kind == KIND_POP) && (count == '0)))
    |=> $stable(count))
    else $error("rejected item changed the entry count");

  // The compare step never runs at the head slot
  a_cmp_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH_CMP) |-> (slot != '0))
    else $error("compare step at head slot");

  // Placing the new entry grows the queue by one
  a_push_inc: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH_CMP) && keep_order |=> count == $past(count) + 1'b1)
    else $error("insert did not increment the entry count");

  // A result is only offered while the output slot can take it
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done.valid |-> res_free && (state == S_FINISH))
    else $error("result issued with output slot occupied");

endmodule

FILE: rtl/sorted_priority_queue.sv
// Sequence: a pop or rejected item passes through the head and finish states; a push first
// walks back over m entries (at most CAPACITY-1), moving each of them back one slot.
// Throughput: one item at a time, next item taken from the same cycle the result goes valid;
// the walk takes a registered RAM read, then a write back, for each moved entry.
// Reset: synchronous, clears the entry count, head pointer and handshake state;
// the entry RAM is not cleared and only positions holding entries are ever read.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int ELEM_WIDTH = 32,
  parameter int PRIO_WIDTH = 8
) (
  input logic       clk,
  input logic       rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int AddrWidth = $clog2(CAPACITY);
  localparam int CntWidth  = $clog2(CAPACITY + 1);
  localparam int DataWidth = ELEM_WIDTH + PRIO_WIDTH;

  logic                  seq_idle;
  logic                  start;
  logic                  res_free;
  spq_done_t             done;
  logic [ELEM_WIDTH-1:0] head_elem;
  logic [PRIO_WIDTH-1:0] head_prio;
  logic [CntWidth-1:0]   count;
  logic                  wr_en;
  logic [AddrWidth-1:0]  wr_addr;
  logic [DataWidth-1:0]  wr_data;
  logic                  rd_en;
  logic [AddrWidth-1:0]  rd_addr;
  logic [DataWidth-1:0]  rd_data;

  logic                  rsp_valid;
  logic [ELEM_WIDTH-1:0] rsp_elem;
  logic [PRIO_WIDTH-1:0] rsp_prio;
  logic                  rsp_empty;
  logic [CntWidth-1:0]   rsp_count;
  logic [1:0]            rsp_status;

  // Input handshake
  assign req.ready = seq_idle;
  assign start     = req.valid && seq_idle;
  assign res_free  = !rsp_valid || rsp.ready;

  spq_ram #(
    .WIDTH (DataWidth),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  spq_seq #(
    .CAPACITY   (CAPACITY),
    .ELEM_WIDTH (ELEM_WIDTH),
    .PRIO_WIDTH (PRIO_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (req.kind),
    .elem      (req.elem),
    .prio      (req.priority_req),
    .res_free  (res_free),
    .idle      (seq_idle),
    .done      (done),
    .head_elem (head_elem),
    .head_prio (head_prio),
    .count     (count),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // Output register: holds the result item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done.valid) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done.valid) begin
      rsp_elem   <= head_elem;
      rsp_prio   <= head_prio;
      rsp_empty  <= done.empty;
      rsp_count  <= count;
      rsp_status <= done.status;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.top_elem     = rsp_elem;
  assign rsp.top_priority = rsp_prio;
  assign rsp.is_empty     = rsp_empty;
  assign rsp.count        = rsp_count;
  assign rsp.status       = rsp_status;

endmodule

FILE: sim/sorted_priority_queue_checker.sv
// Scoreboard for the sorted priority queue: keeps its own sorted copy and checks every result.
module sorted_priority_queue_checker import spq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  spq_req_if   req,
  spq_rsp_if   rsp,
  output int   errors,
  output int   awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  // One stored entry, and the view of the queue head returned per item
  typedef struct packed {
    logic [31:0] elem;
    logic [7:0]  prio;
  } slot_t;

  typedef struct packed {
    logic [31:0] top_elem;
    logic [7:0]  top_priority;
    logic        is_empty;
    logic [4:0]  count;
    spq_status_t status;
  } head_view_t;

  slot_t      held[$];
  head_view_t heads_due[$];

  initial begin
    errors  = 0;
    awaited = 0;
  end

  // Apply one push or pop to the shadow queue and return the resulting head view
  function automatic head_view_t apply_op(input logic kind, input logic [31:0] elem,
                                          input logic [7:0] prio);
    head_view_t view;
    slot_t      fresh;
    int         pos;
    view.status = ST_OK;
    if (kind == KIND_PUSH) begin
      if (held.size() >= CAPACITY) begin
        view.status = ST_FULL;
      end else begin
        // new entry goes behind every entry of greater or equal priority
        pos = 0;
        while (pos < held.size() && held[pos].prio >= prio) pos++;
        fresh.elem = elem;
        fresh.prio = prio;
        held.insert(pos, fresh);
      end
    end else if (held.size() == 0) begin
      view.status = ST_EMPTY;
    end else begin
      void'(held.pop_front());
    end
    if (held.size() == 0) begin
      view.top_elem     = '0;
      view.top_priority = '0;
      view.is_empty     = 1'b1;
    end else begin
      view.top_elem     = held[0].elem;
      view.top_priority = held[0].prio;
      view.is_empty     = 1'b0;
    end
    view.count = 5'(held.size());
    return view;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Record accepted requests, then match accepted results in order
  always @(posedge clk) begin
    head_view_t want;
    if (rst) begin
      held.delete();
      heads_due.delete();
    end else begin
      if (req.valid && req.ready)
        heads_due.push_back(apply_op(req.kind, req.elem, req.priority_req));
      if (rsp.valid && rsp.ready) begin
        if (heads_due.size() == 0) begin
          $error("result item with no request outstanding");
          errors++;
        end else begin
          want = heads_due.pop_front();
          check_field("top_elem", want.top_elem, rsp.top_elem);
          check_field("top_priority", 32'(want.top_priority), 32'(rsp.top_priority));
          check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
          check_field("count", 32'(want.count), 32'(rsp.count));
          check_field("status", 32'(want.status), 32'(rsp.status));
        end
      end
    end
    awaited = heads_due.size();
  end

endmodule

FILE: sim/sorted_priority_queue_test.sv
// Top of the sorted priority queue test: clock, reset, stimulus and verdict.
module sorted_priority_queue_test import spq_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 16;
  localparam int RANDOM_OPS  = 1330;
  localparam int CHUNK_OPS   = 40;
  localparam int SQUEEZE_CYC = 400;

  logic clk;
  logic rst;
  logic steady;   // when set, neither side idles
  logic squeeze;  // asks the receiver for its long hold-off
  int   errors;
  int   awaited;

  spq_req_if #(.ELEM_WIDTH(32), .PRIO_WIDTH(8)) req_ch ();
  spq_rsp_if #(.CAPACITY(CAPACITY), .ELEM_WIDTH(32), .PRIO_WIDTH(8)) rsp_ch ();

  sorted_priority_queue #(
    .CAPACITY  (CAPACITY),
    .ELEM_WIDTH(32),
    .PRIO_WIDTH(8)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  sorted_priority_queue_checker #(.CAPACITY(CAPACITY)) scoreboard (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .errors (errors),
    .awaited(awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the queue hangs
  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady) return 0;
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item and hold it until the queue takes it
  task automatic offer_op(input logic kind, input logic [31:0] elem, input logic [7:0] prio);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.kind         <= kind;
    req_ch.elem         <= elem;
    req_ch.priority_req <= prio;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Priorities bunch on a few values so ties are common
  function automatic logic [7:0] pick_prio();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? 8'hff : 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_elem();
    case ($urandom_range(0, 15))
      0:       return 32'h0;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random ready pattern, plus one long hold-off on request
  initial begin
    int  run;
    int  gap;
    bit  squeezed;
    squeezed     = 1'b0;
    rsp_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYC) @(negedge clk);
      end
      run = $urandom_range(1, 12);
      rsp_ch.ready <= 1'b1;
      repeat (run) @(negedge clk);
      gap = idle_cycles();
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Sender: reset, directed items, random phases, then drain and verdict
  initial begin
    int push_pct;
    rst                 = 1'b1;
    steady              = 1'b0;
    squeeze             = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.kind         = KIND_PUSH;
    req_ch.elem         = '0;
    req_ch.priority_req = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // pop on empty, a single entry in and out, then empty again
    offer_op(KIND_POP, 32'h1234_5678, 8'h5a);
    offer_op(KIND_PUSH, 32'hffff_ffff, 8'hff);
    offer_op(KIND_POP, 32'h0, 8'h0);
    // fill with extremes and equal priorities, then push once too many
    offer_op(KIND_PUSH, 32'h0, 8'h00);
    offer_op(KIND_PUSH, 32'h1, 8'h80);
    offer_op(KIND_PUSH, 32'h2, 8'h80);
    offer_op(KIND_PUSH, 32'h3, 8'h80);
    offer_op(KIND_PUSH, 32'hffff_ffff, 8'hff);
    offer_op(KIND_PUSH, 32'h5, 8'h01);
    repeat (CAPACITY - 6) offer_op(KIND_PUSH, $urandom, 8'($urandom));
    offer_op(KIND_PUSH, 32'hdead_beef, 8'hff);
    repeat (4) offer_op(KIND_POP, $urandom, 8'($urandom));

    // random phases that lean towards full, balanced or empty
    squeeze <= 1'b1;
    for (int done = 0; done < RANDOM_OPS; done += CHUNK_OPS) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      steady <= ($urandom_range(0, 4) == 0);
      repeat (CHUNK_OPS) begin
        if ($urandom_range(0, 99) < push_pct)
          offer_op(KIND_PUSH, pick_elem(), pick_prio());
        else
          offer_op(KIND_POP, $urandom, 8'($urandom));
      end
    end
    req_ch.valid <= 1'b0;

    // wait for every result, then a little longer for strays
    while (awaited != 0) @(negedge clk);
    repeat (2 * CAPACITY + 20) @(negedge clk);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/spq_pkg.sv
rtl/spq_req_if.sv
rtl/spq_rsp_if.sv
rtl/spq_ram.sv
rtl/spq_seq.sv
rtl/sorted_priority_queue.sv
sim/sorted_priority_queue_checker.sv
sim/sorted_priority_queue_test.sv
